>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is held low.
`define IDB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IDB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/idb_pkg.sv
package idb_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 7;
  localparam int CMD_W   = 4;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_REPLACE    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 4'd8;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
  } idb_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_data;
    logic                      ok;
    logic [COUNT_W-1:0]        count;
  } idb_out_t;

  typedef enum logic [3:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_READ,
    OP_REPLACE,
    OP_INSERT,
    OP_REMOVE,
    OP_REMOVE_ALL,
    OP_NONE
  } idb_op_t;

  typedef struct packed {
    idb_op_t                   op;
    logic [DATA_W-1:0]         value;
    logic [INDEX_W-1:0]        index;
  } idb_job_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DRAIN,
    BS_PUTV,
    BS_WAIT,
    BS_DONE
  } idb_bstate_t;

  typedef enum logic [1:0] {
    SC_UP,
    SC_DOWN,
    SC_FILT
  } idb_scan_t;

endpackage

>>> rtl/indexed_deque_buffer.sv
// The back end works on one command at a time: insert, push front, remove, pop front and
//   remove all move words in the store, so they take longer the more words they move. A
//   stalled result holds the back end once its next command is ready to report. Reset (rst_n
//   low, synchronous) empties the buffer, the queue and the front register; the word store
//   is not cleared.
module indexed_deque_buffer #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  idb_pkg::idb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output idb_pkg::idb_out_t out_data
);
  import idb_pkg::*;

  // The front end registers each input beat and turns the command code into
  // an operation. Unused codes become a no-op that the back end refuses.
  // A two-entry queue sits between front and back, so the input side keeps
  // taking beats while the back end is busy moving words around, until it fills.
  //
  // The back end owns the word store (one write and one registered read per
  // cycle) and the entry count. Insert and push front move words up by one
  // place starting from the tail; remove and pop front move them down from
  // the removed position; remove all streams every word through a compare
  // and writes the survivors back in order. Reads and writes overlap so one
  // word moves per cycle. Each finished command lands in an output register,
  // so a stalled result never blocks the next command in the back end until
  // that next one is itself ready to report.

  logic     fq_valid;
  logic     fq_ready;
  idb_job_t fq_job;
  logic     qb_valid;
  logic     qb_ready;
  idb_job_t qb_job;

  idb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  idb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  idb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/idb_front.sv
module idb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  idb_pkg::idb_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output idb_pkg::idb_job_t job
);
  import idb_pkg::*;

  logic     fv_r;
  idb_job_t job_r;
  idb_op_t  dec_op;

  // Unused command codes become a no-op that is refused in the back end.
  always_comb begin
    case (in_data.cmd)
      CMD_PUSH_BACK:  dec_op = OP_PUSH_BACK;
      CMD_PUSH_FRONT: dec_op = OP_PUSH_FRONT;
      CMD_POP_BACK:   dec_op = OP_POP_BACK;
      CMD_POP_FRONT:  dec_op = OP_POP_FRONT;
      CMD_READ:       dec_op = OP_READ;
      CMD_REPLACE:    dec_op = OP_REPLACE;
      CMD_INSERT:     dec_op = OP_INSERT;
      CMD_REMOVE:     dec_op = OP_REMOVE;
      CMD_REMOVE_ALL: dec_op = OP_REMOVE_ALL;
      default:        dec_op = OP_NONE;
    endcase
  end

  assign in_ready  = !fv_r || job_ready;
  assign job_valid = fv_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r.op    <= dec_op;
      job_r.value <= in_data.value;
      job_r.index <= in_data.index;
    end
  end

endmodule

>>> rtl/idb_queue.sv
module idb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  idb_pkg::idb_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output idb_pkg::idb_job_t pop_job
);
  import idb_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  idb_job_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [LW-1:0]   fill_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = fill_r != LW'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_job    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

>>> rtl/idb_back.sv
module idb_back #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  idb_pkg::idb_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output idb_pkg::idb_out_t out_data
);
  import idb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  idb_bstate_t       state_r,  state_nxt;
  logic [CW-1:0]     cnt_r,    cnt_nxt;
  logic [DATA_W-1:0] val_r,    val_nxt;
  logic [AW-1:0]     pos_r,    pos_nxt;
  logic [AW-1:0]     rp_r,     rp_nxt;
  logic [AW-1:0]     last_r,   last_nxt;
  idb_scan_t         mode_r,   mode_nxt;
  logic              pend_r,   pend_nxt;
  logic [AW-1:0]     pa_r,     pa_nxt;
  logic [CW-1:0]     dst_r,    dst_nxt;
  logic [DATA_W-1:0] data_r,   data_nxt;
  logic              ok_r,     ok_nxt;
  logic              rd_r,     rd_nxt;
  logic              ovld_r,   ovld_nxt;
  idb_out_t          out_r,    out_nxt;

  logic [IW-1:0]     ci;
  logic [IW-1:0]     cc;
  logic [IW-1:0]     ins_pos;
  logic              full;
  logic [CW-1:0]     cnt_m1;
  logic              do_pend;

  assign ci      = IW'(job.index);
  assign cc      = IW'(cnt_r);
  assign ins_pos = (job.op == OP_PUSH_FRONT) ? '0 : ci;
  assign full    = cnt_r == CW'(CAPACITY);
  assign cnt_m1  = cnt_r - CW'(1);
  assign do_pend = (state_r == BS_SCAN && pend_r) || state_r == BS_DRAIN;

  assign out_valid = ovld_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    rp_nxt    = rp_r;
    last_nxt  = last_r;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    pa_nxt    = pa_r;
    dst_nxt   = dst_r;
    data_nxt  = data_r;
    ok_nxt    = ok_r;
    rd_nxt    = rd_r;
    ovld_nxt  = ovld_r && !out_ready;
    out_nxt   = out_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata_r;
    mem_re    = 1'b0;
    mem_raddr = rp_r;
    job_ready = 1'b0;

    // Data read in the previous cycle of a scan lands here.
    if (do_pend) begin
      case (mode_r)
        SC_UP: begin
          mem_we    = 1'b1;
          mem_waddr = pa_r + AW'(1);
        end
        SC_DOWN: begin
          if (pa_r != pos_r) begin
            mem_we    = 1'b1;
            mem_waddr = pa_r - AW'(1);
          end else begin
            data_nxt = rdata_r;
          end
        end
        SC_FILT: begin
          if (rdata_r != val_r) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(dst_r);
            dst_nxt   = dst_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      BS_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          val_nxt   = job.value;
          ok_nxt    = 1'b0;
          rd_nxt    = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = BS_DONE;
          case (job.op)
            OP_PUSH_BACK: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_r);
                mem_wdata = job.value;
                cnt_nxt   = cnt_r + CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            OP_PUSH_FRONT, OP_INSERT: begin
              if (ins_pos <= cc && !full) begin
                cnt_nxt = cnt_r + CW'(1);
                ok_nxt  = 1'b1;
                pos_nxt = AW'(ins_pos);
                if (ins_pos == cc) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(ins_pos);
                  mem_wdata = job.value;
                end else begin
                  rp_nxt    = AW'(cnt_m1);
                  last_nxt  = AW'(ins_pos);
                  mode_nxt  = SC_UP;
                  state_nxt = BS_SCAN;
                end
              end
            end
            OP_POP_BACK: begin
              if (cnt_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(cnt_m1);
                cnt_nxt   = cnt_m1;
                ok_nxt    = 1'b1;
                rd_nxt    = 1'b1;
                state_nxt = BS_WAIT;
              end
            end
            OP_POP_FRONT: begin
              if (cnt_r != '0) begin
                cnt_nxt   = cnt_m1;
                ok_nxt    = 1'b1;
                rd_nxt    = 1'b1;
                pos_nxt   = '0;
                rp_nxt    = '0;
                last_nxt  = AW'(cnt_m1);
                mode_nxt  = SC_DOWN;
                state_nxt = BS_SCAN;
              end
            end
            OP_READ: begin
              if (ci < cc) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(ci);
                ok_nxt    = 1'b1;
                rd_nxt    = 1'b1;
                state_nxt = BS_WAIT;
              end
            end
            OP_REPLACE: begin
              if (ci < cc) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(ci);
                mem_wdata = job.value;
                ok_nxt    = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (ci < cc) begin
                cnt_nxt   = cnt_m1;
                ok_nxt    = 1'b1;
                pos_nxt   = AW'(ci);
                rp_nxt    = AW'(ci);
                last_nxt  = AW'(cnt_m1);
                mode_nxt  = SC_DOWN;
                state_nxt = BS_SCAN;
              end
            end
            OP_REMOVE_ALL: begin
              ok_nxt = 1'b1;
              if (cnt_r != '0) begin
                rp_nxt    = '0;
                last_nxt  = AW'(cnt_m1);
                dst_nxt   = '0;
                mode_nxt  = SC_FILT;
                state_nxt = BS_SCAN;
              end
            end
            default: begin
            end
          endcase
        end else begin
          state_nxt = BS_IDLE;
        end
      end
      BS_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = rp_r;
        pend_nxt  = 1'b1;
        pa_nxt    = rp_r;
        if (rp_r == last_r) begin
          state_nxt = BS_DRAIN;
        end else if (mode_r == SC_UP) begin
          rp_nxt = rp_r - AW'(1);
        end else begin
          rp_nxt = rp_r + AW'(1);
        end
      end
      BS_DRAIN: begin
        pend_nxt = 1'b0;
        if (mode_r == SC_UP) begin
          state_nxt = BS_PUTV;
        end else begin
          if (mode_r == SC_FILT) begin
            cnt_nxt = dst_nxt;
          end
          state_nxt = BS_DONE;
        end
      end
      BS_PUTV: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        state_nxt = BS_DONE;
      end
      BS_WAIT: begin
        data_nxt  = rdata_r;
        state_nxt = BS_DONE;
      end
      BS_DONE: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt          = 1'b1;
          out_nxt.read_data = rd_r ? data_r : '1;
          out_nxt.ok        = ok_r;
          out_nxt.count     = COUNT_W'(cnt_r);
          state_nxt         = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    rp_r   <= rp_nxt;
    last_r <= last_nxt;
    mode_r <= mode_nxt;
    pa_r   <= pa_nxt;
    dst_r  <= dst_nxt;
    data_r <= data_nxt;
    ok_r   <= ok_nxt;
    rd_r   <= rd_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule

>>> rtl/idb_checker.sv
`include "assert_macros.svh"

module idb_checker #(
  parameter int CAPACITY = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input idb_pkg::idb_out_t out_data
);
  import idb_pkg::*;

  logic out_wait;
  logic refused;
  logic count_fits;

  assign out_wait   = out_valid && !out_ready;
  assign refused    = out_valid && !out_data.ok;
  assign count_fits = (CAPACITY > 127) || (int'(out_data.count) <= CAPACITY);

  // A result beat that waits must not change.
  `IDB_ASSERT(a_out_hold, clk, rst_n, out_wait |=> out_valid && $stable(out_data), "held result changed")

  // A refused command never carries read data.
  `IDB_ASSERT(a_refused_no_data, clk, rst_n, refused |-> out_data.read_data == -32'sd1, "refused with data")

  // The reported count never goes past the capacity.
  `IDB_ASSERT(a_count_bound, clk, rst_n, out_valid |-> count_fits, "count above capacity")

  // Coming out of reset the block shows no result and takes input.
  `IDB_ASSERT_ALWAYS(a_reset_clean, clk, $past(!rst_n) |-> !out_valid && in_ready, "unclean after reset")

endmodule

bind indexed_deque_buffer idb_checker #(.CAPACITY(CAPACITY)) u_idb_checker (.*);
